### hw/rtl/gbts_pkg.sv
// gbts_pkg: shared types and constants for the gap buffer text store
// no dependencies

package gbts_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned PosW     = 11;
  localparam int unsigned LenW     = 11;
  localparam int unsigned ChrW     = 8;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_ERASE  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SPARE = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]      kind;
    logic [PosW-1:0] position;
    logic [ChrW-1:0] char_in;
    logic [LenW-1:0] erase_length;
  } req_t;

  typedef struct packed {
    logic [ChrW-1:0] char_out;
    logic [LenW-1:0] text_length;
    logic [1:0]      status;
  } rsp_t;

  // classified command handed from the front part to the back part
  typedef struct packed {
    kind_e           kind;
    logic [PosW-1:0] position;
    logic [ChrW-1:0] char_in;
    logic [LenW-1:0] erase_length;
  } cmd_t;

endpackage

### hw/rtl/gbts_req_if.sv
// gbts_req_if / gbts_rsp_if: valid-ready channels of the text store
// depends on gbts_pkg

interface gbts_req_if;
  logic            valid;
  logic            ready;
  gbts_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gbts_rsp_if;
  logic            valid;
  logic            ready;
  gbts_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/gap_buffer_text_store.sv
// gap_buffer_text_store: top level of the gap buffer text store
// depends on gbts_pkg, gbts_req_if, gbts_front, gbts_back
//
// usage
//   req: one item per operation (kind, position, char_in, erase_length)
//   rsp: one item per request (char_out, text_length, status), in order
//   both channels are valid/ready; an item moves when both are high
// operations
//   a read addresses the store directly and leaves the gap in place
//   an insert or erase first moves the gap to the position; the store
//   has a read and a write port and copies one byte per cycle
// structure
//   front part queues two items so requests are taken while the back works
//   back part owns the store and the gap pointers
// reset
//   asynchronous, active low; text empty, gap covers the store
//   store contents are not cleared
// stall
//   a stalled response holds; the queue fills and then req ready drops

module gap_buffer_text_store (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbts_req_if.sink   req,
  gbts_rsp_if.source rsp
);
  import gbts_pkg::*;

  // classified items between front and back
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  gbts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .in_data_i   (req.data),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // back part answers one item at a time
  gbts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .rsp_o       (rsp.data)
  );

endmodule

### hw/rtl/gbts_front.sv
// gbts_front: accepts request items and queues them for the back part
// depends on gbts_pkg

module gbts_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gbts_pkg::req_t     in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output gbts_pkg::cmd_t     cmd_o
);
  import gbts_pkg::*;

  localparam int unsigned Depth = 2;

  cmd_t       fifo_q [Depth];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cls;
  logic       push, pop;

  always_comb begin
    cls.kind         = kind_e'(in_data_i.kind);
    cls.position     = in_data_i.position;
    cls.char_in      = in_data_i.char_in;
    cls.erase_length = in_data_i.erase_length;
  end

  assign in_ready_o  = (cnt_q != 2'(Depth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(Depth)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(Depth)) |-> !push) else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("count slip");

endmodule

### hw/rtl/gbts_back.sv
// gbts_back: carries out reads, inserts and erases on the gap store
// depends on gbts_pkg

module gbts_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  gbts_pkg::cmd_t     cmd_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output gbts_pkg::rsp_t     rsp_o
);
  import gbts_pkg::*;

  localparam int unsigned GapW = AddrW + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LEFT = 6'b000010,
    S_RGHT = 6'b000100,
    S_RDWT = 6'b001000,
    S_FIN  = 6'b010000,
    S_RESP = 6'b100000
  } state_e;

  logic [ChrW-1:0] mem [Capacity];

  state_e          st_q, st_d;
  logic [GapW-1:0] gs_q, gs_d, ge_q, ge_d;
  logic [GapW-1:0] tgt_q, tgt_d;
  logic [LenW-1:0] el_q, el_d;
  cmd_t            cmd_q, cmd_d;
  rsp_t            rsp_q, rsp_d;
  logic [ChrW-1:0] rd_q;
  logic            rd_zero_q, rd_zero_d;
  logic [1:0]      stat_q, stat_d;

  // memory port requests
  logic            re, we;
  logic [AddrW-1:0] ra, wa;
  logic [ChrW-1:0] wdat;
  logic            cp_pend_q, cp_pend_d;
  logic [AddrW-1:0] cp_wa_q, cp_wa_d;

  logic [GapW-1:0] len;
  logic [GapW-1:0] pos_c;
  logic [GapW-1:0] elen_c;
  logic [GapW-1:0] room;

  assign len   = gs_q + GapW'(Capacity) - ge_q;
  assign cmd_ready_o = (st_q == S_IDLE);
  assign rsp_valid_o = (st_q == S_RESP);
  assign rsp_o       = rsp_q;

  always_comb begin
    pos_c  = (GapW'(cmd_i.position) > len) ? len : GapW'(cmd_i.position);
    room   = len - GapW'(cmd_i.position);
    elen_c = (GapW'(cmd_i.erase_length) > room) ? room : GapW'(cmd_i.erase_length);
  end

  always_comb begin
    st_d      = st_q;
    gs_d      = gs_q;
    ge_d      = ge_q;
    tgt_d     = tgt_q;
    el_d      = el_q;
    cmd_d     = cmd_q;
    rsp_d     = rsp_q;
    rd_zero_d = rd_zero_q;
    stat_d    = stat_q;
    cp_pend_d = 1'b0;
    cp_wa_d   = cp_wa_q;
    re        = 1'b0;
    ra        = '0;
    we        = cp_pend_q;
    wa        = cp_wa_q;
    wdat      = rd_q;
    unique case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d     = cmd_i;
          stat_d    = ST_DONE;
          rd_zero_d = 1'b1;
          tgt_d     = pos_c;
          el_d      = LenW'(elen_c);
          unique case (cmd_i.kind)
            KIND_READ: begin
              if (GapW'(cmd_i.position) >= len) begin
                stat_d = ST_RANGE;
                st_d   = S_FIN;
              end else begin
                re        = 1'b1;
                rd_zero_d = 1'b0;
                ra = (GapW'(cmd_i.position) < gs_q) ? AddrW'(cmd_i.position)
                   : AddrW'(ge_q + GapW'(cmd_i.position) - gs_q);
                st_d = S_RDWT;
              end
            end
            KIND_INSERT: begin
              if (gs_q == ge_q) begin
                stat_d = ST_FULL;
                st_d   = S_FIN;
              end else begin
                st_d = S_LEFT;
              end
            end
            KIND_ERASE: begin
              if (cmd_i.erase_length == '0) begin
                st_d = S_FIN;
              end else if (GapW'(cmd_i.position) >= len) begin
                stat_d = ST_RANGE;
                st_d   = S_FIN;
              end else begin
                st_d = S_LEFT;
              end
            end
            default: st_d = S_FIN;
          endcase
        end
      end
      // one byte copied per cycle; read now, write next cycle
      S_LEFT: begin
        if (gs_q > tgt_q) begin
          re        = 1'b1;
          ra        = AddrW'(gs_q - 1'b1);
          cp_pend_d = 1'b1;
          cp_wa_d   = AddrW'(ge_q - 1'b1);
          gs_d      = gs_q - 1'b1;
          ge_d      = ge_q - 1'b1;
        end else if (gs_q < tgt_q) begin
          re        = 1'b1;
          ra        = AddrW'(ge_q);
          cp_pend_d = 1'b1;
          cp_wa_d   = AddrW'(gs_q);
          gs_d      = gs_q + 1'b1;
          ge_d      = ge_q + 1'b1;
        end else begin
          st_d = S_RGHT;
        end
      end
      S_RGHT: begin
        if (cmd_q.kind == KIND_INSERT) begin
          we   = 1'b1;
          wa   = AddrW'(gs_q);
          wdat = cmd_q.char_in;
          gs_d = gs_q + 1'b1;
        end else begin
          ge_d = ge_q + GapW'(el_q);
        end
        st_d = S_FIN;
      end
      S_RDWT: st_d = S_FIN;
      S_FIN: begin
        rsp_d.char_out    = rd_zero_q ? '0 : rd_q;
        rsp_d.text_length = LenW'(len);
        rsp_d.status      = stat_q;
        st_d              = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready_i) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      gs_q      <= '0;
      ge_q      <= GapW'(Capacity);
      cp_pend_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      gs_q      <= gs_d;
      ge_q      <= ge_d;
      cp_pend_q <= cp_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q     <= tgt_d;
    el_q      <= el_d;
    cmd_q     <= cmd_d;
    rsp_q     <= rsp_d;
    rd_zero_q <= rd_zero_d;
    stat_q    <= stat_d;
    cp_wa_q   <= cp_wa_d;
  end

  always_ff @(posedge clk_i) begin
    if (re) rd_q <= mem[ra];
    if (we) mem[wa] <= wdat;
  end

  a_gap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gs_q <= ge_q) else $error("gap start past gap end");
  a_gap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ge_q <= GapW'(Capacity)) else $error("gap end past capacity");
  a_copy_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_RGHT) |-> !cp_pend_q)
    else $error("copy pending");
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> rsp_valid_o) else $error("response dropped");

endmodule

### bench/gbts_tb_if.sv
`timescale 1ns / 1ps
// gbts_tb_if: bench-side note file; the channels come from gbts_req_if.sv
// depends on gbts_pkg
// (kept for the bench folder layout; holds a small helper package)

package gbts_tb_pkg;
  import gbts_pkg::*;
  // one expected response as the bench holds it
  typedef struct packed {
    logic [ChrW-1:0] char_out;
    logic [LenW-1:0] text_length;
    status_e         status;
  } exp_rsp_t;
endpackage

### bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for the gap buffer text store
// depends on gbts_pkg, gbts_req_if, gbts_tb_pkg and the rtl top level

module tb;
  import gbts_pkg::*;
  import gbts_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gbts_req_if req ();
  gbts_rsp_if rsp ();

  gap_buffer_text_store u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .rsp    (rsp.source)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the text, held as a plain logical string
  logic [7:0]  shadow_text [0:Capacity-1];
  int unsigned shadow_len;
  exp_rsp_t    pending_rsp [$];
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;

  // predict one request and update the shadow text
  function automatic exp_rsp_t predict_edit(req_t r);
    exp_rsp_t    e;
    int unsigned p;
    int unsigned n;
    e.char_out = '0;
    e.status   = ST_DONE;
    p = r.position;
    n = r.erase_length;
    case (kind_e'(r.kind))
      KIND_READ: begin
        if (p >= shadow_len) e.status = ST_RANGE;
        else e.char_out = shadow_text[p];
      end
      KIND_INSERT: begin
        if (p > shadow_len) p = shadow_len;
        if (shadow_len == Capacity) begin
          e.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > p; i--) shadow_text[i] = shadow_text[i-1];
          shadow_text[p] = r.char_in;
          shadow_len++;
        end
      end
      KIND_ERASE: begin
        if (n != 0) begin
          if (p >= shadow_len) begin
            e.status = ST_RANGE;
          end else begin
            if (n > shadow_len - p) n = shadow_len - p;
            for (int i = p; i + n < shadow_len; i++) shadow_text[i] = shadow_text[i+n];
            shadow_len -= n;
          end
        end
      end
      default: ;
    endcase
    e.text_length = shadow_len[LenW-1:0];
    return e;
  endfunction

  // send one request, with random idling before it
  task automatic send_op(kind_e k, int unsigned p, logic [7:0] c, int unsigned n);
    req_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    r.kind         = k;
    r.position     = p[PosW-1:0];
    r.char_in      = c;
    r.erase_length = n[LenW-1:0];
    req.valid <= 1'b1;
    req.data  <= r;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pending_rsp = {pending_rsp, predict_edit(r)};
  endtask

  task automatic drain_wait();
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // response ready with random stalls
  always @(posedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each accepted response with the oldest expectation
  always @(posedge clk_i) begin
    exp_rsp_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response %h", $time, rsp.data);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.data.char_out !== e.char_out || rsp.data.text_length !== e.text_length ||
            rsp.data.status !== e.status) begin
          $display("%0t: mismatch expected chr %h len %0d st %0d, got chr %h len %0d st %0d",
                   $time, e.char_out, e.text_length, e.status, rsp.data.char_out,
                   rsp.data.text_length, rsp.data.status);
          errors++;
        end
      end
    end
  end

  // reads on an empty text, inserts past the end, and other special cases
  task automatic test_directed();
    send_op(KIND_READ, 0, 8'h00, 0);
    send_op(KIND_ERASE, 0, 8'h00, 1);
    send_op(KIND_ERASE, 2047, 8'h00, 0);
    send_op(KIND_INSERT, 2047, 8'hff, 0);
    send_op(KIND_INSERT, 0, 8'h00, 0);
    send_op(KIND_INSERT, 1, 8'haa, 2047);
    send_op(KIND_INSERT, 1, 8'h55, 0);
    send_op(KIND_READ, 0, 8'hff, 2047);
    send_op(KIND_READ, 3, 8'h00, 0);
    send_op(KIND_READ, 2047, 8'h00, 0);
    send_op(KIND_NONE, 1, 8'h12, 3);
    send_op(KIND_ERASE, 1, 8'h00, 2047);
    send_op(KIND_ERASE, 5, 8'h00, 1);
    send_op(KIND_READ, 1, 8'h00, 0);
    send_op(KIND_ERASE, 0, 8'h00, 1024);
  endtask

  // fill the store to capacity and probe the full case at both ends
  task automatic test_full();
    while (shadow_len < Capacity)
      send_op(KIND_INSERT, $urandom_range(shadow_len), 8'($urandom), 0);
    send_op(KIND_INSERT, 0, 8'h11, 0);
    send_op(KIND_INSERT, 1024, 8'h22, 0);
    send_op(KIND_READ, 1023, 8'h00, 0);
    send_op(KIND_READ, 1024, 8'h00, 0);
    send_op(KIND_ERASE, 1020, 8'h00, 2047);
    send_op(KIND_ERASE, 0, 8'h00, 1010);
  endtask

  // random mix, mostly local edits near the previous position
  task automatic test_random(int count);
    int unsigned p;
    int unsigned sel;
    p = 0;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 8) p = $urandom_range(2047);
      else if (sel < 30) p = $urandom_range(shadow_len + 2);
      else p = (p + $urandom_range(6)) % (shadow_len + 2);
      sel = $urandom_range(99);
      if (sel < 35) send_op(KIND_READ, p, 8'($urandom), $urandom_range(2047));
      else if (sel < 75) send_op(KIND_INSERT, p, 8'($urandom), $urandom_range(2047));
      else if (sel < 97)
        send_op(KIND_ERASE, p, 8'($urandom), ($urandom_range(9) == 0) ?
                $urandom_range(2047) : $urandom_range(4));
      else send_op(KIND_NONE, p, 8'($urandom), $urandom_range(2047));
    end
  endtask

  initial begin
    errors = 0;
    shadow_len = 0;
    send_idle_pct = 29;
    recv_idle_pct = 74;
    req.valid = 1'b0;
    req.data  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(40);
    // sender holds off until the response queue is empty
    drain_wait();
    send_idle_pct = 74;
    recv_idle_pct = 29;
    test_full();
    test_random(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(40);
    drain_wait();
    repeat (2100) @(posedge clk_i);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // overall watchdog
  initial begin
    #200ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule
